/* design/aots_pkg.sv */
// package for the alien order topological sort block
// holds sizes, payload structs, queue record and state types; no dependencies
`timescale 1ns / 1ps
package aots_pkg;

	// sizes
	localparam int MAX_NODES    = 32;
	localparam int NODE_W       = 5;
	localparam int CNT_W        = 6;
	localparam int MAX_WORD_LEN = 64;
	localparam int WPOS_W       = 6;
	localparam int POS_W        = 7;
	localparam int MAX_EDGES    = 64;
	localparam int EIDX_W       = 6;
	localparam int ECNT_W       = 7;
	localparam int MAP_DEPTH    = 256;
	localparam int Q_DEPTH      = 4;
	localparam int QIDX_W       = 2;
	localparam int QCNT_W       = 3;
	localparam logic [CNT_W-1:0] K_RESET = 6'd26;

	// input word
	typedef struct packed {
		logic [7:0] character;
		logic       last_of_word;
		logic       last_of_list;
	} item_t;

	// result word
	typedef struct packed {
		logic [7:0] order_char;
		logic       last;
		logic       overflow;
	} result_t;

	// record passed from the front to the back
	typedef struct packed {
		logic              new_v;
		logic [7:0]        nchar;
		logic              edge_v;
		logic [NODE_W-1:0] esrc;
		logic [NODE_W-1:0] edst;
		logic              fin;
		logic              ovf;
	} qrec_t;

	// queue status toward the front and back
	typedef struct packed {
		logic full;
		logic empty;
	} qstat_t;

	typedef struct packed {
		logic [NODE_W-1:0] src;
		logic [NODE_W-1:0] dst;
	} edge_t;

	typedef enum logic [1:0] {
		F_CLEAR,
		F_IDLE,
		F_LOOK
	} front_state_t;

	typedef enum logic [2:0] {
		B_LOAD,
		B_ROOT,
		B_SCAN,
		B_CHK,
		B_EMIT
	} back_state_t;

endpackage

/* design/aots_queue.sv */
// short record queue between the front and the back
// depends on aots_pkg
`timescale 1ns / 1ps
module aots_queue import aots_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  qrec_t  wdata,
	input  logic   pop,
	output qrec_t  rdata,
	output qstat_t stat
);

	qrec_t             mem_q [Q_DEPTH];
	logic [QIDX_W-1:0] wp_q;
	logic [QIDX_W-1:0] rp_q;
	logic [QCNT_W-1:0] cnt_q;

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + 1'b1;
			if (pop) rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + QCNT_W'(push) - QCNT_W'(pop);
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= wdata;
	end

	assign rdata      = mem_q[rp_q];
	assign stat.full  = (cnt_q == QCNT_W'(Q_DEPTH));
	assign stat.empty = (cnt_q == '0);

endmodule

/* design/aots_front.sv */
// front: takes characters, assigns node numbers, compares words, finds edges
// depends on aots_pkg; feeds records into aots_queue
`timescale 1ns / 1ps
module aots_front import aots_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  item_t            item,
	output logic             busy,
	input  logic [CNT_W-1:0] k,
	input  qstat_t           qs,
	output logic             push,
	output qrec_t            prec
);

	typedef struct packed {
		logic              valid;
		logic [NODE_W-1:0] node;
	} mape_t;

	typedef struct packed {
		logic              mapped;
		logic [NODE_W-1:0] node;
		logic [7:0]        ch;
	} wbe_t;

	front_state_t fst_q, fst_n;

	mape_t map_mem [MAP_DEPTH];
	wbe_t  wb_mem [2*MAX_WORD_LEN];
	mape_t map_rd_q;
	wbe_t  wb_rd_q;

	logic [7:0]        c_s1;
	logic              eow_s1;
	logic              eol_s1;
	logic [7:0]        clr_q;
	logic [POS_W-1:0]  pos_q;
	logic [POS_W-1:0]  prev_len_q;
	logic              decided_q;
	logic              first_q;
	logic              bank_q;
	logic [CNT_W-1:0]  dc_q;
	logic [ECNT_W-1:0] ecnt_q;
	logic              ovf_q;

	logic              accept;
	logic              look;
	logic              in_range;
	logic              new_node;
	logic              c_mapped;
	logic [NODE_W-1:0] c_node;
	logic              cmp;
	logic              want_edge;
	logic              edge_ok;
	logic              ovf_all;
	logic [CNT_W-1:0]  dc_next;
	logic              map_we;
	logic [7:0]        map_wa;
	mape_t             map_wd;
	logic              wb_we;
	wbe_t              wb_wd;

	assign accept = (fst_q == F_IDLE) && start && !qs.full;
	assign look   = (fst_q == F_LOOK);
	assign busy   = (fst_q != F_IDLE) || qs.full;

	// classification of the word under lookup
	always_comb begin
		in_range  = pos_q < POS_W'(MAX_WORD_LEN);
		new_node  = in_range && !map_rd_q.valid && (dc_q < CNT_W'(MAX_NODES));
		c_mapped  = map_rd_q.valid || new_node;
		c_node    = map_rd_q.valid ? map_rd_q.node : dc_q[NODE_W-1:0];
		cmp       = in_range && !first_q && !decided_q && (pos_q < prev_len_q)
			&& (wb_rd_q.ch != c_s1);
		want_edge = cmp && wb_rd_q.mapped && c_mapped;
		edge_ok   = want_edge && (ecnt_q < ECNT_W'(MAX_EDGES));
		ovf_all   = ovf_q || !in_range || (!map_rd_q.valid && !c_mapped)
			|| (want_edge && !edge_ok);
		dc_next   = dc_q + CNT_W'(new_node);
	end

	// next state
	always_comb begin
		fst_n = fst_q;
		unique case (fst_q)
			F_CLEAR: if (clr_q == 8'hFF) fst_n = F_IDLE;
			F_IDLE:  if (accept) fst_n = F_LOOK;
			F_LOOK:  fst_n = eol_s1 ? F_CLEAR : F_IDLE;
			default: fst_n = F_CLEAR;
		endcase
	end

	// outputs: memory writes and queue push
	always_comb begin
		map_we      = 1'b0;
		map_wa      = c_s1;
		map_wd      = '{valid: 1'b1, node: dc_q[NODE_W-1:0]};
		wb_we       = 1'b0;
		wb_wd       = '{mapped: c_mapped, node: c_node, ch: c_s1};
		push        = 1'b0;
		prec.new_v  = new_node;
		prec.nchar  = c_s1;
		prec.edge_v = edge_ok;
		prec.esrc   = wb_rd_q.node;
		prec.edst   = c_node;
		prec.fin    = eol_s1;
		prec.ovf    = ovf_all || (dc_next > k);
		unique case (fst_q)
			F_CLEAR: begin
				map_we = 1'b1;
				map_wa = clr_q;
				map_wd = '0;
			end
			F_LOOK: begin
				map_we = new_node;
				wb_we  = in_range;
				push   = new_node || edge_ok || eol_s1;
			end
			default: begin
				map_we = 1'b0;
			end
		endcase
	end

	// lookup memories
	always_ff @(posedge clk) begin
		if (accept) begin
			map_rd_q <= map_mem[item.character];
			wb_rd_q  <= wb_mem[{~bank_q, pos_q[WPOS_W-1:0]}];
		end
		if (map_we) map_mem[map_wa] <= map_wd;
		if (wb_we) wb_mem[{bank_q, pos_q[WPOS_W-1:0]}] <= wb_wd;
	end

	// accepted word held for the lookup cycle
	always_ff @(posedge clk) begin
		if (accept) begin
			c_s1   <= item.character;
			eow_s1 <= item.last_of_word;
			eol_s1 <= item.last_of_list;
		end
	end

	// list state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fst_q      <= F_CLEAR;
			clr_q      <= '0;
			pos_q      <= '0;
			prev_len_q <= '0;
			decided_q  <= 1'b0;
			first_q    <= 1'b1;
			bank_q     <= 1'b0;
			dc_q       <= '0;
			ecnt_q     <= '0;
			ovf_q      <= 1'b0;
		end else begin
			fst_q <= fst_n;
			if (fst_q == F_CLEAR) clr_q <= clr_q + 1'b1;
			if (look) begin
				if (eol_s1) begin
					// list done: back to the empty list
					pos_q      <= '0;
					prev_len_q <= '0;
					decided_q  <= 1'b0;
					first_q    <= 1'b1;
					bank_q     <= 1'b0;
					dc_q       <= '0;
					ecnt_q     <= '0;
					ovf_q      <= 1'b0;
				end else if (eow_s1) begin
					// word done: swap banks
					dc_q       <= dc_next;
					ecnt_q     <= ecnt_q + ECNT_W'(edge_ok);
					ovf_q      <= ovf_all;
					prev_len_q <= in_range ? pos_q + 1'b1 : pos_q;
					bank_q     <= ~bank_q;
					pos_q      <= '0;
					decided_q  <= 1'b0;
					first_q    <= 1'b0;
				end else begin
					dc_q   <= dc_next;
					ecnt_q <= ecnt_q + ECNT_W'(edge_ok);
					ovf_q  <= ovf_all;
					if (cmp) decided_q <= 1'b1;
					if (in_range) pos_q <= pos_q + 1'b1;
				end
			end
		end
	end

endmodule

/* design/aots_back.sv */
// back: stores nodes and edges, runs the depth-first walk, emits the order
// depends on aots_pkg; drains records from aots_queue
`timescale 1ns / 1ps
module aots_back import aots_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [CNT_W-1:0] k,
	input  qstat_t           qs,
	input  qrec_t            qrec,
	output logic             pop,
	output logic             result_valid,
	output result_t          result
);

	back_state_t bst_q, bst_n;

	logic [7:0]        n2c_q [MAX_NODES];
	edge_t             emem [MAX_EDGES];
	edge_t             emem_rd_q;
	logic [NODE_W-1:0] stk_node_q [MAX_NODES];
	logic [ECNT_W-1:0] stk_edge_q [MAX_NODES];
	logic [NODE_W-1:0] post_q [MAX_NODES];
	logic [MAX_NODES-1:0] visited_q;
	logic [CNT_W-1:0]  dcnt_q;
	logic [ECNT_W-1:0] ecnt_q;
	logic [CNT_W-1:0]  sp_q;
	logic [CNT_W-1:0]  pcnt_q;
	logic [CNT_W-1:0]  root_q;
	logic [CNT_W-1:0]  emit_q;
	logic              ovf_q;
	logic              rv_q;
	result_t           res_q;

	logic [NODE_W-1:0] top_idx;
	logic [NODE_W-1:0] u;
	logic [ECNT_W-1:0] e;
	logic              has_more;
	logic              match;
	logic              descend;
	logic              scan_rd;
	logic              emit_last;
	logic [NODE_W-1:0] en;
	logic [7:0]        ech;

	// walk stack top and edge check
	always_comb begin
		top_idx   = NODE_W'(sp_q - 1'b1);
		u         = stk_node_q[top_idx];
		e         = stk_edge_q[top_idx];
		has_more  = e < ecnt_q;
		match     = (emem_rd_q.src == u) && ({1'b0, emem_rd_q.dst} < k);
		descend   = match && !visited_q[emem_rd_q.dst] && (sp_q < CNT_W'(MAX_NODES));
		emit_last = (emit_q + 1'b1) == pcnt_q;
		en        = post_q[NODE_W'(pcnt_q - 1'b1 - emit_q)];
		ech       = ({1'b0, en} < dcnt_q) ? n2c_q[en] : 8'd0;
	end

	// next state
	always_comb begin
		bst_n = bst_q;
		unique case (bst_q)
			B_LOAD: if (pop && qrec.fin) bst_n = B_ROOT;
			B_ROOT: begin
				if (root_q == k) bst_n = B_EMIT;
				else if (!visited_q[root_q[NODE_W-1:0]]) bst_n = B_SCAN;
			end
			B_SCAN: begin
				if (has_more) bst_n = B_CHK;
				else if (sp_q == CNT_W'(1)) bst_n = B_ROOT;
			end
			B_CHK:  bst_n = B_SCAN;
			B_EMIT: if (emit_last) bst_n = B_LOAD;
			default: bst_n = B_LOAD;
		endcase
	end

	// outputs: queue pop and edge memory read
	always_comb begin
		pop     = 1'b0;
		scan_rd = 1'b0;
		unique case (bst_q)
			B_LOAD:  pop = !qs.empty;
			B_SCAN:  scan_rd = has_more;
			default: pop = 1'b0;
		endcase
	end

	// edge memory
	always_ff @(posedge clk) begin
		if (scan_rd) emem_rd_q <= emem[e[EIDX_W-1:0]];
		if (pop && qrec.edge_v) emem[ecnt_q[EIDX_W-1:0]] <= '{src: qrec.esrc, dst: qrec.edst};
	end

	// node names, stacks and result payload
	always_ff @(posedge clk) begin
		if (pop && qrec.new_v) n2c_q[dcnt_q[NODE_W-1:0]] <= qrec.nchar;
		if (bst_q == B_ROOT && root_q != k && !visited_q[root_q[NODE_W-1:0]]) begin
			stk_node_q[0] <= root_q[NODE_W-1:0];
			stk_edge_q[0] <= '0;
		end
		if (bst_q == B_SCAN && !has_more && pcnt_q < CNT_W'(MAX_NODES))
			post_q[pcnt_q[NODE_W-1:0]] <= u;
		if (bst_q == B_CHK) begin
			stk_edge_q[top_idx] <= e + 1'b1;
			if (descend) begin
				stk_node_q[sp_q[NODE_W-1:0]] <= emem_rd_q.dst;
				stk_edge_q[sp_q[NODE_W-1:0]] <= '0;
			end
		end
		res_q <= '{order_char: ech, last: emit_last, overflow: ovf_q};
	end

	// walk control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bst_q     <= B_LOAD;
			visited_q <= '0;
			dcnt_q    <= '0;
			ecnt_q    <= '0;
			sp_q      <= '0;
			pcnt_q    <= '0;
			root_q    <= '0;
			emit_q    <= '0;
			ovf_q     <= 1'b0;
			rv_q      <= 1'b0;
		end else begin
			bst_q <= bst_n;
			rv_q  <= (bst_q == B_EMIT);
			unique case (bst_q)
				B_LOAD: begin
					if (pop) begin
						dcnt_q <= dcnt_q + CNT_W'(qrec.new_v);
						ecnt_q <= ecnt_q + ECNT_W'(qrec.edge_v);
						if (qrec.fin) ovf_q <= qrec.ovf;
					end
				end
				B_ROOT: begin
					if (root_q != k) begin
						if (visited_q[root_q[NODE_W-1:0]]) begin
							root_q <= root_q + 1'b1;
						end else begin
							visited_q[root_q[NODE_W-1:0]] <= 1'b1;
							sp_q <= CNT_W'(1);
						end
					end
				end
				B_SCAN: begin
					if (!has_more) begin
						sp_q <= sp_q - 1'b1;
						if (pcnt_q < CNT_W'(MAX_NODES)) pcnt_q <= pcnt_q + 1'b1;
						if (sp_q == CNT_W'(1)) root_q <= root_q + 1'b1;
					end
				end
				B_CHK: begin
					if (descend) begin
						visited_q[emem_rd_q.dst] <= 1'b1;
						sp_q <= sp_q + 1'b1;
					end
				end
				B_EMIT: begin
					if (emit_last) begin
						visited_q <= '0;
						dcnt_q    <= '0;
						ecnt_q    <= '0;
						pcnt_q    <= '0;
						root_q    <= '0;
						emit_q    <= '0;
					end else begin
						emit_q <= emit_q + 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	assign result_valid = rv_q;
	assign result       = res_q;

endmodule

/* design/alien_order_topo_sort.sv */
// Derives a character order from a sorted word list, one character per start
// pulse. A character passes through a map lookup, then a classify step; busy
// also rises while the record queue is full. After the last character of a
// list the front runs a pass that clears all 256 character map entries (also
// after reset), while the back walks the graph: B_ROOT per root, B_SCAN and
// B_CHK per edge examined for each node on the stack, B_SCAN per pop, then one
// result word per cycle, one per node of the effective alphabet size (zero
// counts as one, above 32 counts as 32), all in a row. result_valid is high
// for exactly one cycle per result word and cannot be held off by the receiver.
// depends on aots_pkg, aots_front, aots_queue, aots_back
`timescale 1ns / 1ps
module alien_order_topo_sort import aots_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  item_t            item,
	output logic             busy,
	input  logic             cfg_we,
	input  logic [CNT_W-1:0] cfg_wdata,
	output logic             result_valid,
	output result_t          result
);

	logic [CNT_W-1:0] k_q;
	logic [CNT_W-1:0] k_eff;
	qstat_t           qs;
	logic             push;
	logic             pop;
	qrec_t            wrec;
	qrec_t            rrec;

	// alphabet size register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) k_q <= K_RESET;
		else if (cfg_we) k_q <= cfg_wdata;
	end

	// zero counts as one, large values saturate
	always_comb begin
		if (k_q == '0) k_eff = CNT_W'(1);
		else if (k_q > CNT_W'(MAX_NODES)) k_eff = CNT_W'(MAX_NODES);
		else k_eff = k_q;
	end

	aots_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.item   (item),
		.busy   (busy),
		.k      (k_eff),
		.qs     (qs),
		.push   (push),
		.prec   (wrec)
	);

	aots_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (wrec),
		.pop    (pop),
		.rdata  (rrec),
		.stat   (qs)
	);

	aots_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.k            (k_eff),
		.qs           (qs),
		.qrec         (rrec),
		.pop          (pop),
		.result_valid (result_valid),
		.result       (result)
	);

	// results of one list come out in consecutive cycles
	a_burst: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.last |=> result_valid)
		else $error("gap inside result burst");

	// a gap always follows the final word of a list
	a_gap: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.last |=> !result_valid)
		else $error("result right after final word");

	// overflow is the same for every word of a list
	a_ovf: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.last |=> result.overflow == $past(result.overflow))
		else $error("overflow changed inside a list");

	// nothing is pushed into a full queue
	a_push: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !qs.full || pop)
		else $error("push into full queue");

endmodule
